// File: src/i2ra_pkg.sv
package i2ra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IN_WIDTH        = 32;
  localparam int BASE_WIDTH      = 5;
  localparam int DIGIT_WIDTH     = 4;
  localparam int CHAR_WIDTH      = 8;
  // dividend bits consumed per cycle by the digit divider
  localparam int CHUNK           = 8;

  localparam logic [BASE_WIDTH-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = 5'd16;

  localparam logic [DIGIT_WIDTH-1:0] DEC_DIGITS = 4'd10;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // load a new word
    logic div_step;    // run one chunk of the digit divide
    logic load_ptr;    // copy digit count into the read pointer
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the next digit into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_last;   // this divide step finishes a digit
    logic quot_zero;   // quotient after this step is zero
    logic cnt_full;    // digit store is about to fill
    logic sign;        // a minus sign precedes the digits
    logic ptr_one;     // one digit left to send
    logic out_free;    // output register can take a word this cycle
  } sts_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d,
                                                        input logic lower);
    logic [CHAR_WIDTH-1:0] ext;
    ext = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, d};
    if (d < DEC_DIGITS) begin
      digit_char = CHAR_ZERO + ext;
    end else if (lower) begin
      digit_char = CHAR_LOWER_A + ext - {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, DEC_DIGITS};
    end else begin
      digit_char = CHAR_UPPER_A + ext - {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, DEC_DIGITS};
    end
  endfunction

endpackage

// File: src/i2ra_dp.sv
module i2ra_dp #(
  parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  i2ra_pkg::cmd_t                      cmd,
  output i2ra_pkg::sts_t                      sts,
  input  logic [i2ra_pkg::IN_WIDTH-1:0]       value,
  input  logic [i2ra_pkg::BASE_WIDTH-1:0]     base,
  input  logic                                unsigned_mode,
  input  logic                                lowercase,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [i2ra_pkg::CHAR_WIDTH-1:0]     out_char,
  output logic                                last_char
);

  localparam int CHUNK = i2ra_pkg::CHUNK;
  localparam int STEPS = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PW    = STEPS * CHUNK;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DW    = i2ra_pkg::DIGIT_WIDTH;
  localparam int BW    = i2ra_pkg::BASE_WIDTH;

  logic [VALUE_WIDTH-1:0] word;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic [BW-1:0]          base_sat;

  logic [PW-1:0]   dividend, dividend_next;
  logic [DW-1:0]   rem, rem_next;
  logic [BW-1:0]   base_q;
  logic            lower;
  logic            sign;
  logic [SW-1:0]   step;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   ptr, ptr_next, ptr_dec;
  logic [AW-1:0]   rd_addr;
  logic [DW-1:0]   rd_data;
  logic [DW-1:0]   mem [VALUE_WIDTH];

  logic [DW-1:0]    r;
  logic [DW:0]      t;
  logic [CHUNK-1:0] q;
  logic             step_last;

  generate
    if (VALUE_WIDTH <= i2ra_pkg::IN_WIDTH) begin : g_trunc
      assign word = value[VALUE_WIDTH-1:0];
    end else begin : g_ext
      assign word = {{(VALUE_WIDTH-i2ra_pkg::IN_WIDTH){1'b0}}, value};
    end
  endgenerate

  assign neg = !unsigned_mode && word[VALUE_WIDTH-1];
  assign mag = neg ? (~word + 1'b1) : word;

  always_comb begin
    if (base < i2ra_pkg::BASE_MIN) begin
      base_sat = i2ra_pkg::BASE_MIN;
    end else if (base > i2ra_pkg::BASE_MAX) begin
      base_sat = i2ra_pkg::BASE_MAX;
    end else begin
      base_sat = base;
    end
  end

  // restoring divide over one chunk; remainder stays below the base
  always_comb begin
    r = rem;
    t = '0;
    q = '0;
    for (int i = 0; i < CHUNK; i++) begin
      t = {r, dividend[PW-1-i]};
      if (t >= base_q) begin
        q[CHUNK-1-i] = 1'b1;
        t = t - base_q;
      end
      r = t[DW-1:0];
    end
    rem_next      = r;
    dividend_next = (dividend << CHUNK) | PW'(q);
  end

  assign step_last = (step == SW'(STEPS - 1));

  always_comb begin
    if (cmd.load_ptr) begin
      ptr_next = cnt;
    end else if (cmd.emit_digit) begin
      ptr_next = ptr - CW'(1);
    end else begin
      ptr_next = ptr;
    end
  end

  assign ptr_dec = ptr_next - CW'(1);
  assign rd_addr = ptr_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dividend <= '0;
      rem      <= '0;
      sign     <= 1'b0;
      step     <= '0;
      cnt      <= '0;
      ptr      <= '0;
    end else begin
      ptr <= ptr_next;
      if (cmd.accept) begin
        dividend <= PW'(mag);
        rem      <= '0;
        sign     <= neg;
        step     <= '0;
        cnt      <= '0;
      end else if (cmd.div_step) begin
        dividend <= dividend_next;
        if (step_last) begin
          rem  <= '0;
          step <= '0;
          cnt  <= cnt + CW'(1);
        end else begin
          rem  <= rem_next;
          step <= step + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_q <= base_sat;
      lower  <= lowercase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last) begin
      mem[cnt[AW-1:0]] <= rem_next;
    end
    rd_data <= mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char  <= i2ra_pkg::CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char  <= i2ra_pkg::digit_char(rd_data, lower);
      last_char <= (ptr == CW'(1));
    end
  end

  assign sts.step_last = step_last;
  assign sts.quot_zero = (dividend_next == '0);
  assign sts.cnt_full  = (cnt == CW'(VALUE_WIDTH - 1));
  assign sts.sign      = sign;
  assign sts.ptr_one   = (ptr == CW'(1));
  assign sts.out_free  = !out_valid || !out_stall;

`ifndef ASSERT_OFF
  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (BW'(rem) < base_q))
    else $error("divider remainder not below base");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (ptr != '0) && (ptr <= cnt))
    else $error("digit read outside stored digits");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit && (ptr == CW'(1)) |=> out_valid && last_char)
    else $error("final digit not flagged as last");
`endif

endmodule

// File: src/i2ra_ctrl.sv
module i2ra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  i2ra_pkg::sts_t sts,
  output i2ra_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIV,
    PREP,
    SIGN,
    EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != IDLE);
    case (state)
      IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last && (sts.quot_zero || sts.cnt_full)) begin
          state_next = sts.sign ? SIGN : PREP;
        end
      end
      PREP: begin
        cmd.load_ptr = 1'b1;
        state_next   = EMIT;
      end
      SIGN: begin
        cmd.load_ptr  = 1'b1;
        cmd.emit_sign = sts.out_free;
        if (sts.out_free) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        cmd.emit_digit = sts.out_free;
        if (sts.out_free && sts.ptr_one) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/integer_to_radix_ascii.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------------------------
// in      | sink      | in_valid / in_stall   | value, base, unsigned_mode, lowercase
// out     | source    | out_valid / out_stall | out_char, last_char
//
// Sequence: take the word, divide out each digit (8 quotient bits a cycle), set up the
//   digit read (it also sends any minus sign), then send the digits while out is not stalled.
// The next word is taken once the last character sits in the output register.
// Reset (rst, synchronous, active high) clears the controller, counters and the
//   output valid; the digit store is not cleared. A stall on out holds the output word.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [i2ra_pkg::IN_WIDTH-1:0]   value,
  input  logic [i2ra_pkg::BASE_WIDTH-1:0] base,
  input  logic                            unsigned_mode,
  input  logic                            lowercase,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [i2ra_pkg::CHAR_WIDTH-1:0] out_char,
  output logic                            last_char
);

  i2ra_pkg::cmd_t cmd;
  i2ra_pkg::sts_t sts;

  // Sequencer: take a word, run the digit divide, then send sign and digits.
  i2ra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Magnitude, chunked divider, digit store and output register.
  i2ra_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .value         (value),
    .base          (base),
    .unsigned_mode (unsigned_mode),
    .lowercase     (lowercase),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .last_char     (last_char)
  );

`ifndef ASSERT_OFF
  // Characters of one number leave back to back: no bubble inside a number.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_char |=> out_valid)
    else $error("gap inside a number's characters");
`endif

endmodule

// File: bench/integer_to_radix_ascii_tb.sv
module integer_to_radix_ascii_tb;

  // Give up on a hung run well past the slowest legal run: each word at most
  // 33 characters, a full base-2 divide and the longest receiver stall stretches.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // Bound on the wait for outstanding characters once stimulus is done.
  localparam int          SETTLE_LIMIT = 100_000;
  // Quiet cycles after the last character; covers one full base-2 word.
  localparam int          TAIL_CYCLES  = 200;

  // One expected character on the out channel.
  typedef struct packed {
    logic [i2ra_pkg::CHAR_WIDTH-1:0] ch;
    logic                            last;
  } char_t;

  // Receiver stall behavior.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_PATTERN,
    RX_RANDOM,
    RX_HEAVY
  } rx_mode_t;

  localparam logic [15:0] RX_PATTERN_BITS = 16'b0110_0011_1000_0101;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            in_valid      = 1'b0;
  logic                            in_stall;
  logic [i2ra_pkg::IN_WIDTH-1:0]   value         = '0;
  logic [i2ra_pkg::BASE_WIDTH-1:0] base          = i2ra_pkg::BASE_MIN;
  logic                            unsigned_mode = 1'b0;
  logic                            lowercase     = 1'b0;
  logic                            out_valid;
  logic                            out_stall     = 1'b0;
  logic [i2ra_pkg::CHAR_WIDTH-1:0] out_char;
  logic                            last_char;

  // Characters predicted but not yet seen, oldest first.
  char_t       pending_chars[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Sender burst shaping: gap_max of zero keeps valid high back to back.
  int          gap_max    = 4;
  int          burst_max  = 6;
  int          burst_left = 3;

  rx_mode_t    rx_mode     = RX_PATTERN;
  int          rx_phase    = 0;
  int          rx_stretch  = 0;

  integer_to_radix_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .base          (base),
    .unsigned_mode (unsigned_mode),
    .lowercase     (lowercase),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .last_char     (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop on a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Work out the characters one word turns into and queue them up.
  // Signed mode negates a word with the top bit set and leads with a minus;
  // the most negative word negates to itself, which is the right magnitude.
  // The magnitude is divided down, remainders collected most significant
  // first, and a zero magnitude still yields one '0'.
  function automatic void predict_chars(input logic [i2ra_pkg::IN_WIDTH-1:0]   word,
                                        input logic [i2ra_pkg::BASE_WIDTH-1:0] radix,
                                        input logic                            unsig,
                                        input logic                            lower);
    string                            alphabet;
    logic [i2ra_pkg::IN_WIDTH-1:0]    mag;
    logic [i2ra_pkg::IN_WIDTH-1:0]    divisor;
    logic [i2ra_pkg::DIGIT_WIDTH-1:0] digits[$];
    char_t                            c;
    if (lower) begin
      alphabet = "0123456789abcdef";
    end else begin
      alphabet = "0123456789ABCDEF";
    end
    // Saturate the radix into the legal range.
    divisor = i2ra_pkg::IN_WIDTH'(radix);
    if (radix < i2ra_pkg::BASE_MIN) begin
      divisor = i2ra_pkg::IN_WIDTH'(i2ra_pkg::BASE_MIN);
    end else if (radix > i2ra_pkg::BASE_MAX) begin
      divisor = i2ra_pkg::IN_WIDTH'(i2ra_pkg::BASE_MAX);
    end
    mag = word;
    if (!unsig && word[i2ra_pkg::IN_WIDTH-1]) begin
      c.ch   = i2ra_pkg::CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
      mag = -word;
    end
    do begin
      digits.push_front(i2ra_pkg::DIGIT_WIDTH'(mag % divisor));
      mag = mag / divisor;
    end while (mag != 0);
    foreach (digits[i]) begin
      c.ch   = alphabet[digits[i]];
      c.last = (i == digits.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Pick a word that stresses the conversion: tiny values, full-range noise,
  // neighbors of the sign and width limits, and powers of the radix +/- 1
  // where the digit count steps.
  function automatic logic [i2ra_pkg::IN_WIDTH-1:0] pick_word(
      input logic [i2ra_pkg::BASE_WIDTH-1:0] radix);
    logic [63:0] power;
    int          steps;
    pick_word = '0;
    case ($urandom_range(0, 5))
      0: pick_word = $urandom_range(0, 40);
      1: pick_word = $urandom;
      2: begin
        case ($urandom_range(0, 2))
          0:       pick_word = 32'hFFFF_FFFF - $urandom_range(0, 20);
          1:       pick_word = 32'h8000_0000 + $urandom_range(0, 20);
          default: pick_word = 32'h7FFF_FFFF - $urandom_range(0, 20);
        endcase
      end
      3: begin
        power = 64'd1;
        steps = $urandom_range(1, 31);
        repeat (steps) begin
          if (power * radix <= 64'hFFFF_FFFF) begin
            power = power * radix;
          end
        end
        pick_word = power[i2ra_pkg::IN_WIDTH-1:0] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) begin
          pick_word = -pick_word;
        end
      end
      default: pick_word = $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Offer one word and hold it until taken. Called at a falling edge.
  // After the handshake, either keep valid up for the next word of the
  // burst or drop it for a random gap and scramble the idle payload.
  task automatic send_word(input logic [i2ra_pkg::IN_WIDTH-1:0]   word,
                           input logic [i2ra_pkg::BASE_WIDTH-1:0] radix,
                           input logic                            unsig,
                           input logic                            lower);
    value         <= word;
    base          <= radix;
    unsigned_mode <= unsig;
    lowercase     <= lower;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_chars(word, radix, unsig, lower);
    @(negedge clk);
    if (gap_max != 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        value    <= $urandom;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, burst_max);
      end
    end
  endtask

  // Send a word with random radix, sign mode and letter case.
  task automatic send_random_word();
    logic [i2ra_pkg::BASE_WIDTH-1:0] radix;
    radix = i2ra_pkg::BASE_WIDTH'($urandom_range(i2ra_pkg::BASE_MIN, i2ra_pkg::BASE_MAX));
    send_word(pick_word(radix), radix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: stall on a mode chosen by the running test. Drive at the
  // falling edge so the block samples a settled stall.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_phase = (rx_phase + 1) % 16;
      case (rx_mode)
        RX_FREE:    out_stall <= 1'b0;
        RX_PATTERN: out_stall <= RX_PATTERN_BITS[rx_phase];
        RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          // Long stretches of stall with short random windows between them.
          if (rx_stretch > 0) begin
            rx_stretch--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_stretch = $urandom_range(5, 25);
            out_stall <= 1'b1;
          end else begin
            out_stall <= ($urandom_range(0, 1) == 1);
          end
        end
      endcase
    end
  end

  // Compare each character taken from the block against the oldest one
  // predicted.
  always @(posedge clk) begin
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("out_char: expected none, actual %h", out_char);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, out_char);
          mismatch_count++;
        end
        if (last_char !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, last_char);
          mismatch_count++;
        end
      end
    end
  end

  // Corners: zero, all-ones, the sign boundary, longest strings, letters.
  task automatic test_directed_corners();
    rx_mode   = RX_PATTERN;
    gap_max   = 3;
    burst_max = 4;
    send_word(32'h0000_0000, 5'd10, 1'b0, 1'b0);
    send_word(32'h0000_0000, 5'd2,  1'b1, 1'b0);
    send_word(32'h0000_0000, 5'd16, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 5'd10, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 5'd10, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 5'd2,  1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 5'd16, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 5'd16, 1'b1, 1'b0);
    // Most negative word in base 2: sign plus 32 digits, the longest output.
    send_word(32'h8000_0000, 5'd2,  1'b0, 1'b0);
    send_word(32'h8000_0000, 5'd10, 1'b0, 1'b1);
    send_word(32'h8000_0000, 5'd16, 1'b1, 1'b0);
    send_word(32'h7FFF_FFFF, 5'd10, 1'b0, 1'b0);
    send_word(32'h7FFF_FFFF, 5'd3,  1'b0, 1'b0);
    send_word(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b1);
    send_word(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b0);
    send_word(32'hDEAD_BEEF, 5'd16, 1'b0, 1'b1);
    send_word(32'h1234_5678, 5'd7,  1'b1, 1'b0);
    send_word(32'h0000_0001, 5'd2,  1'b0, 1'b0);
    send_word(32'h0000_0009, 5'd10, 1'b1, 1'b0);
    send_word(32'h0000_000A, 5'd11, 1'b0, 1'b1);
    send_word(32'h0000_000F, 5'd16, 1'b0, 1'b0);
    send_word(32'h0000_0010, 5'd16, 1'b0, 1'b0);
    send_word(32'h0000_00FF, 5'd15, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFE, 5'd13, 1'b0, 1'b1);
    send_word(32'h5555_AAAA, 5'd12, 1'b1, 1'b0);
  endtask

  // Random words; every few words reshape both sides, including stretches
  // where neither side idles.
  task automatic test_random_words();
    for (int i = 0; i < 150; i++) begin
      if (i % 15 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
          gap_max = 0;
        end else begin
          gap_max   = $urandom_range(1, 12);
          burst_max = $urandom_range(1, 8);
        end
      end
      send_random_word();
    end
  endtask

  // Back-to-back words into a receiver that never stalls.
  task automatic test_streaming_words();
    rx_mode = RX_FREE;
    gap_max = 0;
    for (int i = 0; i < 40; i++) begin
      send_random_word();
    end
  endtask

  // Long strings against a stall-heavy receiver to pause readout mid-number.
  task automatic test_stalled_readout();
    logic [i2ra_pkg::BASE_WIDTH-1:0] radix;
    rx_mode   = RX_HEAVY;
    gap_max   = 3;
    burst_max = 5;
    for (int i = 0; i < 35; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        radix = i2ra_pkg::BASE_MIN;
      end else begin
        radix = i2ra_pkg::BASE_WIDTH'($urandom_range(i2ra_pkg::BASE_MIN,
                                                     i2ra_pkg::BASE_MAX));
      end
      send_word(pick_word(radix), radix, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int settle;
    settle = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_words();
    test_streaming_words();
    test_stalled_readout();

    // Drop valid, drain what is still owed, then watch for strays.
    in_valid <= 1'b0;
    while (pending_chars.size() != 0 && settle < SETTLE_LIMIT) begin
      @(posedge clk);
      settle++;
    end
    if (pending_chars.size() != 0) begin
      $error("out_char: expected %h, actual none (%0d characters missing)",
             pending_chars[0].ch, pending_chars.size());
      mismatch_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
